### sv/snss_pkg.sv
package snss_pkg;

    // Fixed field widths
    localparam int KIND_W     = 2;
    localparam int VALUE_W    = 28;
    localparam int POS_W      = 3;
    localparam int PATTERN_W  = 7;

    // Default number of display positions
    localparam int DIGITS_DEF = 4;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DASH   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BLANK  = 2'd2;

    // Segment patterns
    localparam logic [PATTERN_W-1:0] SEG_CENTER = 7'h40;
    localparam logic [PATTERN_W-1:0] SEG_BLANK  = 7'h00;

    // One input transaction
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
    } t_item;

    // One display position
    typedef struct packed {
        logic [POS_W-1:0]     position;
        logic [PATTERN_W-1:0] pattern;
        logic                 overflow;
        logic                 last;
    } t_result;

    // Power of ten, evaluated at elaboration or unrolled into constants
    function automatic int unsigned pow10(input int n);
        int unsigned p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    // Decimal digit to segment pattern
    function automatic logic [PATTERN_W-1:0] glyph(input logic [3:0] d);
        logic [PATTERN_W-1:0] g;
        case (d)
            4'd0:    g = 7'h3F;
            4'd1:    g = 7'h06;
            4'd2:    g = 7'h5B;
            4'd3:    g = 7'h4F;
            4'd4:    g = 7'h66;
            4'd5:    g = 7'h6D;
            4'd6:    g = 7'h7D;
            4'd7:    g = 7'h07;
            4'd8:    g = 7'h7F;
            4'd9:    g = 7'h6F;
            default: g = SEG_BLANK;
        endcase
        return g;
    endfunction

endpackage

### sv/snss_in_stage.sv
module snss_in_stage import snss_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_item_valid,
    output t_item o_item,
    input  logic  i_take
);

    logic  r_valid;
    t_item r_item;
    logic  accept;

    // Free when empty or when the sequencer takes the held transaction
    assign o_ready = !r_valid || i_take;
    assign accept  = i_valid && o_ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

### sv/snss_seq.sv
module snss_seq import snss_pkg::*; #(
    parameter int DIGITS = DIGITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_take,
    input  logic    i_adv_ok,
    output logic    o_res_valid,
    output t_result o_res
);

    localparam int REM_W = $clog2(pow10(DIGITS));

    logic                 r_busy;
    logic [POS_W-1:0]     r_pos;
    logic [REM_W-1:0]     r_rem;
    logic [KIND_W-1:0]    r_kind;
    logic                 r_neg;
    logic                 r_ovf;
    logic [POS_W-1:0]     r_lead;

    logic [POS_W-1:0]     n_pos;
    logic [REM_W-1:0]     n_rem;

    logic                 fire;
    logic                 at_end;
    logic                 load;

    logic [VALUE_W-1:0]   ld_raw;
    logic                 ld_neg;
    logic [VALUE_W-1:0]   ld_mag;
    logic                 ld_ovf;
    logic [POS_W-1:0]     ld_count;

    logic [POS_W-1:0]     weight;
    logic [REM_W-1:0]     row [0:9];
    logic [8:0]           ge;
    logic [3:0]           digit;
    logic [PATTERN_W-1:0] pattern;

    // Handshake with the input register and the output register
    assign at_end = (r_pos == POS_W'(DIGITS - 1));
    assign fire   = r_busy && i_adv_ok;
    assign o_take = !r_busy || (fire && at_end);
    assign load   = o_take && i_item_valid;
    assign n_pos  = r_pos + 1'b1;

    // Analyse a new number: magnitude, fit check and count of digits beyond the first
    always_comb begin
        ld_raw   = i_item.value;
        ld_neg   = ld_raw[VALUE_W-1];
        ld_mag   = ld_neg ? (~ld_raw + 1'b1) : ld_raw;
        ld_ovf   = (i_item.kind == KIND_NUMBER) &&
                   (ld_neg ? (ld_mag >= VALUE_W'(pow10(DIGITS - 1)))
                           : (ld_mag >= VALUE_W'(pow10(DIGITS))));
        ld_count = '0;
        for (int j = 1; j < DIGITS; j++) begin
            if (ld_mag >= VALUE_W'(pow10(j))) begin
                ld_count = ld_count + 1'b1;
            end
        end
    end

    // Pick the multiples of the current decimal weight
    assign weight = POS_W'(DIGITS - 1) - r_pos;

    always_comb begin
        for (int c = 0; c < 10; c++) begin
            row[c] = '0;
        end
        for (int k = 0; k < DIGITS; k++) begin
            if (weight == POS_W'(k)) begin
                for (int c = 0; c < 10; c++) begin
                    row[c] = REM_W'(c * pow10(k));
                end
            end
        end
    end

    // Extract the digit at this weight and strip it from the remainder
    always_comb begin
        for (int c = 1; c < 10; c++) begin
            ge[c-1] = (r_rem >= row[c]);
        end
        digit = 4'($countones(ge));
        n_rem = r_rem - row[digit];
    end

    // Segment pattern for this position
    always_comb begin
        case (r_kind)
            KIND_NUMBER: begin
                if (r_ovf) begin
                    pattern = SEG_BLANK;
                end else if (r_pos < r_lead) begin
                    pattern = (r_neg && (r_pos == r_lead - 1'b1)) ? SEG_CENTER : SEG_BLANK;
                end else begin
                    pattern = glyph(digit);
                end
            end
            KIND_DASH: pattern = SEG_CENTER;
            default:   pattern = SEG_BLANK;
        endcase
    end

    // Advance through the positions, load a new request when idle or at the end of a run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_pos  <= '0;
        end else if (fire) begin
            if (at_end) begin
                r_busy <= 1'b0;
            end else begin
                r_pos <= n_pos;
            end
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rem  <= ld_mag[REM_W-1:0];
            r_kind <= i_item.kind;
            r_neg  <= ld_neg;
            r_ovf  <= ld_ovf;
            r_lead <= POS_W'(DIGITS - 1) - ld_count;
        end else if (fire) begin
            r_rem  <= n_rem;
        end
    end

    assign o_res_valid    = r_busy;
    assign o_res.position = r_pos;
    assign o_res.pattern  = pattern;
    assign o_res.overflow = r_ovf;
    assign o_res.last     = at_end;

endmodule

### sv/snss_out_reg.sv
module snss_out_reg import snss_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Take a new position when empty or when the receiver drains this one
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    // Hold the result while stalled
    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### sv/signed_number_seven_segment.sv
// Signed decimal number on a row of DIGITS seven-segment positions.
//
// Input channel (i_valid / o_ready): i_kind selects a number, a row of
// dashes or a blank display; i_value is the signed number. Output channel
// (o_valid / i_ready): one transaction per position, leftmost first, with
// o_position, o_pattern, o_overflow and o_last on the rightmost position.
//
// The first position of a request passes through the input register, the
// digit sequencer and the output register. The digit sequencer hands on one
// position per cycle while the output register is free, extracting one
// decimal digit a cycle, most significant first, by comparing the remainder
// with the multiples of its weight. A following request waits in the input
// register and enters the sequencer in the cycle the last position of the
// current one moves on.
//
// Reset clears every valid flag; no transaction is in flight afterwards.
// When the receiver stalls, the output register holds its position, the
// sequencer and then the input register fill, and o_ready falls.
module signed_number_seven_segment import snss_pkg::*; #(
    parameter int DIGITS = DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [KIND_W-1:0]           i_kind,
    input  logic signed [VALUE_W-1:0]   i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [POS_W-1:0]            o_position,
    output logic [PATTERN_W-1:0]        o_pattern,
    output logic                        o_overflow,
    output logic                        o_last
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    seq_take;
    logic    out_free;
    logic    seq_valid;
    t_result seq_res;
    t_result out_res;

    assign in_item.kind  = i_kind;
    assign in_item.value = i_value;

    // Input register
    snss_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (in_item),
        .o_item_valid (held_valid),
        .o_item       (held_item),
        .i_take       (seq_take)
    );

    // Digit sequencer
    snss_seq #(
        .DIGITS (DIGITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (held_valid),
        .i_item       (held_item),
        .o_take       (seq_take),
        .i_adv_ok     (out_free),
        .o_res_valid  (seq_valid),
        .o_res        (seq_res)
    );

    // Output register
    snss_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (seq_valid),
        .i_res       (seq_res),
        .o_free      (out_free),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (out_res)
    );

    assign o_position = out_res.position;
    assign o_pattern  = out_res.pattern;
    assign o_overflow = out_res.overflow;
    assign o_last     = out_res.last;

    // The end marker sits on the rightmost position only
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_position == POS_W'(DIGITS - 1))))
        else $error("end marker on wrong position");

    // Positions of one request follow each other without a gap
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=>
            (o_valid && (o_position == $past(o_position) + 1'b1)))
        else $error("position sequence broken");

    // An overflowed number shows a blank display
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_pattern == SEG_BLANK))
        else $error("overflow with lit segments");

endmodule

### test/signed_number_seven_segment_tb.sv
`timescale 1ns / 1ps

module signed_number_seven_segment_tb;
    import snss_pkg::*;

    localparam int DIGITS       = DIGITS_DEF;
    localparam int RAND_ITEMS   = 208;
    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = DIGITS + 8;

    // Kind code with no meaning of its own, shown as a blank display
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 28'sh7FF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 28'sh800_0000;

    localparam logic [PATTERN_W-1:0] DIGIT_GLYPH [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_ALTERNATE,
        STALL_RANDOM,
        STALL_LONG
    } t_stall_mode;

    // Directed row: typed rows carry one pattern shared by every position
    typedef struct {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        bit                        typed;
        logic [PATTERN_W-1:0]      pattern;
        logic                      overflow;
    } t_stim_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic [KIND_W-1:0]           i_kind = KIND_BLANK;
    logic signed [VALUE_W-1:0]   i_value = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic [POS_W-1:0]            o_position;
    logic [PATTERN_W-1:0]        o_pattern;
    logic                        o_overflow;
    logic                        o_last;

    t_result     pending_positions[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          cycle_count = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_span = 0;

    signed_number_seven_segment #(
        .DIGITS (DIGITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_kind     (i_kind),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_position (o_position),
        .o_pattern  (o_pattern),
        .o_overflow (o_overflow),
        .o_last     (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint ten_pow(input int n);
        longint p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    // Queue one position per digit with the same pattern everywhere
    function automatic void push_uniform(input logic [PATTERN_W-1:0] pattern,
                                         input logic overflow);
        t_result r;
        for (int i = 0; i < DIGITS; i++) begin
            r.position = POS_W'(i);
            r.pattern  = pattern;
            r.overflow = overflow;
            r.last     = (i == DIGITS - 1);
            pending_positions.push_back(r);
        end
    endfunction

    // Work out the display for one request and queue its positions
    function automatic void predict_display(input logic [KIND_W-1:0] kind,
                                            input logic signed [VALUE_W-1:0] value);
        logic [PATTERN_W-1:0] pat [DIGITS];
        logic                 neg;
        longint               mag;
        int                   room;
        int                   p;
        logic                 ovf;
        t_result              r;
        neg = value[VALUE_W-1];
        mag = neg ? -longint'(value) : longint'(value);
        ovf = 1'b0;
        for (int i = 0; i < DIGITS; i++) begin
            pat[i] = (kind == KIND_DASH) ? SEG_CENTER : SEG_BLANK;
        end
        if (kind == KIND_NUMBER) begin
            room = DIGITS - (neg ? 1 : 0);
            if (room <= 0 || mag >= ten_pow(room)) begin
                ovf = 1'b1;
            end else begin
                // Fill digits from the right, then place the sign
                p = DIGITS - 1;
                do begin
                    pat[p] = DIGIT_GLYPH[mag % 10];
                    mag = mag / 10;
                    p--;
                end while (mag != 0 && p >= 0);
                if (neg && p >= 0) begin
                    pat[p] = SEG_CENTER;
                end
            end
        end
        for (int i = 0; i < DIGITS; i++) begin
            r.position = POS_W'(i);
            r.pattern  = pat[i];
            r.overflow = ovf;
            r.last     = (i == DIGITS - 1);
            pending_positions.push_back(r);
        end
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic signed [VALUE_W-1:0] value);
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
    endtask

    // Hold off the sender until every queued position has come back
    task automatic drain_display;
        i_valid <= 1'b0;
        while (pending_positions.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Pick a number, mostly of a chosen digit count, near the fit limits
    function automatic logic signed [VALUE_W-1:0] random_number;
        logic [31:0] raw;
        int          ndig;
        longint      mag;
        raw = $urandom();
        if ($urandom_range(0, 9) == 0) begin
            return raw[VALUE_W-1:0];
        end
        ndig = $urandom_range(1, DIGITS + 1);
        case ($urandom_range(0, 5))
            0:       mag = ten_pow(ndig) - 1;
            1:       mag = ten_pow(ndig - 1);
            default: mag = $urandom_range(int'(ten_pow(ndig - 1)), int'(ten_pow(ndig) - 1));
        endcase
        if (ndig == 1 && raw[4]) begin
            mag = 0;
        end
        if (mag > longint'(VALUE_MAX)) begin
            mag = longint'(VALUE_MAX);
        end
        return raw[0] ? VALUE_W'(-mag) : VALUE_W'(mag);
    endfunction

    // Receiver: change the stall pattern after a random span
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_span <= $urandom_range(8, 64);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            STALL_NONE:      i_ready <= 1'b1;
            STALL_ALTERNATE: i_ready <= cycle_count[0];
            STALL_RANDOM:    i_ready <= ($urandom_range(0, 9) < 7);
            default:         i_ready <= (cycle_count[3:0] == 4'd0);
        endcase
    end

    // Compare each output transaction with the oldest queued position
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_positions.size() == 0) begin
                $display("%0t: unexpected position %0d pattern %h", $time,
                         o_position, o_pattern);
                error_count++;
            end else begin
                want = pending_positions.pop_front();
                if (o_position !== want.position) begin
                    $display("%0t: position expected %0d actual %0d", $time,
                             want.position, o_position);
                    error_count++;
                end
                if (o_pattern !== want.pattern) begin
                    $display("%0t: pattern at %0d expected %h actual %h", $time,
                             want.position, want.pattern, o_pattern);
                    error_count++;
                end
                if (o_overflow !== want.overflow) begin
                    $display("%0t: overflow at %0d expected %b actual %b", $time,
                             want.position, want.overflow, o_overflow);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last at %0d expected %b actual %b", $time,
                             want.position, want.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_stim_row                 stim_table [];
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        int                        burst_left;
        int                        gap;

        stim_table = '{
            '{KIND_NUMBER, 0, 0, SEG_BLANK, 0},
            '{KIND_NUMBER, 1, 0, SEG_BLANK, 0},
            '{KIND_NUMBER, 9, 0, SEG_BLANK, 0},
            '{KIND_NUMBER, 10, 0, SEG_BLANK, 0},
            '{KIND_NUMBER, 8, 0, SEG_BLANK, 0},
            '{KIND_NUMBER, 123, 0, SEG_BLANK, 0},
            '{KIND_NUMBER, VALUE_W'(ten_pow(DIGITS) - 1), 0, SEG_BLANK, 0},
            '{KIND_NUMBER, VALUE_W'(ten_pow(DIGITS)), 1, SEG_BLANK, 1},
            '{KIND_NUMBER, -1, 0, SEG_BLANK, 0},
            '{KIND_NUMBER, -45, 0, SEG_BLANK, 0},
            '{KIND_NUMBER, VALUE_W'(-(ten_pow(DIGITS - 1) - 1)), 0, SEG_BLANK, 0},
            '{KIND_NUMBER, VALUE_W'(-ten_pow(DIGITS - 1)), 1, SEG_BLANK, 1},
            '{KIND_NUMBER, VALUE_MAX, 1, SEG_BLANK, 1},
            '{KIND_NUMBER, VALUE_MIN, 1, SEG_BLANK, 1},
            '{KIND_NUMBER, VALUE_W'(VALUE_MIN + 1), 1, SEG_BLANK, 1},
            '{KIND_DASH, 0, 1, SEG_CENTER, 0},
            '{KIND_DASH, VALUE_MIN, 1, SEG_CENTER, 0},
            '{KIND_BLANK, VALUE_MAX, 1, SEG_BLANK, 0},
            '{KIND_BLANK, 0, 1, SEG_BLANK, 0},
            '{KIND_UNUSED, VALUE_MAX, 1, SEG_BLANK, 0},
            '{KIND_UNUSED, -1, 1, SEG_BLANK, 0},
            '{KIND_NUMBER, 2, 0, SEG_BLANK, 0}
        };

        // Hold reset, then release it on a rising edge
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows, back to back
        foreach (stim_table[i]) begin
            if (stim_table[i].typed) begin
                push_uniform(stim_table[i].pattern, stim_table[i].overflow);
            end else begin
                predict_display(stim_table[i].kind, stim_table[i].value);
            end
            send_request(stim_table[i].kind, stim_table[i].value);
        end
        drain_display();

        // Random requests in bursts, mostly numbers
        burst_left = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 2) begin
                drain_display();
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            if ($urandom_range(0, 3) != 0) begin
                kind  = KIND_NUMBER;
                value = random_number();
            end else begin
                kind  = KIND_W'($urandom_range(1, 3));
                value = VALUE_W'($urandom());
            end
            predict_display(kind, value);
            send_request(kind, value);
        end

        // Wait out every position, then idle before the verdict
        drain_display();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
